// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks a property on every rising edge of clk_i outside reset
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// checks that a condition never holds outside reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== design/bec_pkg.sv =====
package bec_pkg;

  localparam int SeqDepth = 4;
  localparam int IdxW     = $clog2(SeqDepth);

  localparam logic [7:0] ByteBackslash = 8'h5C;
  localparam logic [7:0] BytePrintLo   = 8'h20;
  localparam logic [7:0] BytePrintHi   = 8'h7E;

  typedef logic [6:0]      char_t;
  typedef logic [IdxW-1:0] idx_t;

  localparam char_t CharBackslash = 7'h5C;
  localparam char_t CharX         = 7'h78;
  localparam char_t CharNone      = 7'h00;

  localparam idx_t LastOne  = idx_t'(0);
  localparam idx_t LastTwo  = idx_t'(1);
  localparam idx_t LastFour = idx_t'(3);

  typedef struct packed {
    char_t text_byte;
    logic  run_last;
    logic  text_end;
  } bec_word_t;

  typedef struct packed {
    char_t [SeqDepth-1:0] chars;
    idx_t                 last;
  } bec_seq_t;

  function automatic char_t bec_hex_digit(input logic [3:0] nib);
    char_t d;
    if (nib < 4'd10) begin
      d = 7'h30 + {3'b000, nib};
    end else begin
      d = 7'h37 + {3'b000, nib};
    end
    return d;
  endfunction

  function automatic char_t bec_control_letter(input logic [7:0] b);
    char_t l;
    unique case (b)
      8'h07:   l = 7'h61;
      8'h08:   l = 7'h62;
      8'h0C:   l = 7'h66;
      8'h0A:   l = 7'h6E;
      8'h0D:   l = 7'h72;
      8'h09:   l = 7'h74;
      8'h0B:   l = 7'h76;
      default: l = CharNone;
    endcase
    return l;
  endfunction

  function automatic bec_seq_t bec_encode(input logic [7:0] b);
    bec_seq_t s;
    char_t    letter;
    s      = '0;
    letter = bec_control_letter(b);
    if (b == ByteBackslash) begin
      s.chars[0] = CharBackslash;
      s.chars[1] = CharBackslash;
      s.last     = LastTwo;
    end else if (b >= BytePrintLo && b <= BytePrintHi) begin
      s.chars[0] = b[6:0];
      s.last     = LastOne;
    end else if (letter != CharNone) begin
      s.chars[0] = CharBackslash;
      s.chars[1] = letter;
      s.last     = LastTwo;
    end else begin
      s.chars[0] = CharBackslash;
      s.chars[1] = CharX;
      s.chars[2] = bec_hex_digit(b[7:4]);
      s.chars[3] = bec_hex_digit(b[3:0]);
      s.last     = LastFour;
    end
    return s;
  endfunction

endpackage

// ===== design/bec_if.sv =====
interface bec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       string_end;

  modport source (output valid, output raw_byte, output string_end, input ready);
  modport sink (input valid, input raw_byte, input string_end, output ready);
endinterface

interface bec_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] text_byte;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output text_byte, output run_last, output text_end,
                  input ready);
  modport sink (input valid, input text_byte, input run_last, input text_end,
                output ready);
endinterface

// ===== design/byte_escape_encoder.sv =====
// Escapes one raw byte per input word into one to four printable output words:
// printable bytes pass as is, backslash doubles, the seven common controls turn into
// a backslash and a letter, and anything else turns into \xHH with uppercase hex.
// run_last marks the final word of each byte and text_end also marks it for the byte
// flagged string_end. Output leaves at one word per cycle through an output register
// while out_o.ready stays high; a byte expands to 1, 2 or 4 words, with 4 the worst
// case. The next byte is taken in the same cycle its predecessor's last word moves on.
module byte_escape_encoder
  import bec_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  bec_in_if.sink    in_i,
  bec_out_if.source out_o
);

  `include "assert_macros.svh"

  logic      take;
  logic      word_valid;
  bec_word_t word;
  logic      out_valid_q, out_valid_d;
  bec_word_t out_word_q;

  bec_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .raw_byte_i   (in_i.raw_byte),
    .string_end_i (in_i.string_end),
    .take_i       (take),
    .word_valid_o (word_valid),
    .word_o       (word)
  );

  assign take = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = word_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && word_valid) begin
      out_word_q <= word;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.text_byte = out_word_q.text_byte;
  assign out_o.run_last  = out_word_q.run_last;
  assign out_o.text_end  = out_word_q.text_end;

  `ASSERT_PROP(a_end_is_run_last, out_valid_q && out_word_q.text_end |-> out_word_q.run_last)
  `ASSERT_PROP(a_word_moves, take && word_valid |=> out_valid_q)

endmodule

// ===== design/bec_seq.sv =====
module bec_seq
  import bec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] raw_byte_i,
  input  logic       string_end_i,
  input  logic       take_i,
  output logic       word_valid_o,
  output bec_word_t  word_o
);

  `include "assert_macros.svh"

  logic                 valid_q, valid_d;
  char_t [SeqDepth-1:0] chars_q;
  idx_t                 last_q;
  idx_t                 idx_q, idx_d;
  logic                 end_q;
  bec_seq_t             enc;
  logic                 advance;
  logic                 finishing;
  logic                 accept;

  assign enc       = bec_encode(raw_byte_i);
  assign advance   = valid_q && take_i;
  assign finishing = advance && (idx_q == last_q);
  assign in_ready_o = !valid_q || finishing;
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (accept) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (finishing) begin
      valid_d = 1'b0;
    end else if (advance) begin
      idx_d = idx_q + idx_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      chars_q <= enc.chars;
      last_q  <= enc.last;
      end_q   <= string_end_i;
    end
  end

  assign word_valid_o     = valid_q;
  assign word_o.text_byte = chars_q[idx_q];
  assign word_o.run_last  = (idx_q == last_q);
  assign word_o.text_end  = (idx_q == last_q) && end_q;

  `ASSERT_PROP(a_idx_in_run, valid_q |-> idx_q <= last_q)
  `ASSERT_PROP(a_accept_starts_run, accept |=> valid_q && idx_q == '0)
  `ASSERT_NEVER(a_odd_run_len, valid_q && last_q == idx_t'(2))

endmodule

// ===== dv/escape_checker.sv =====
module escape_checker
  import bec_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  bec_in_if    in_mon,
  bec_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   words_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] PrintLo   = 8'h20;
  localparam logic [7:0] PrintHi   = 8'h7E;
  localparam logic [7:0] CtlBel    = 8'h07;
  localparam logic [7:0] CtlBs     = 8'h08;
  localparam logic [7:0] CtlHt     = 8'h09;
  localparam logic [7:0] CtlLf     = 8'h0A;
  localparam logic [7:0] CtlVt     = 8'h0B;
  localparam logic [7:0] CtlFf     = 8'h0C;
  localparam logic [7:0] CtlCr     = 8'h0D;
  localparam int         ReportMax = 10;

  bec_word_t text_due_q[$];
  int        mismatches = 0;
  int        words_seen = 0;

  function automatic char_t hex_char(input logic [3:0] nib);
    char_t c;
    if (nib > 4'd9) begin
      c = char_t'("A") + char_t'(nib - 4'd10);
    end else begin
      c = char_t'("0") + char_t'(nib);
    end
    return c;
  endfunction

  // expected escaped text of one raw byte
  function automatic void queue_escape(input logic [7:0] raw, input logic str_end);
    char_t     seq[4];
    int        n;
    bec_word_t w;
    seq[0] = char_t'(Backslash);
    seq[1] = '0;
    seq[2] = '0;
    seq[3] = '0;
    n      = 2;
    case (raw)
      Backslash: seq[1] = char_t'(Backslash);
      CtlBel:    seq[1] = char_t'("a");
      CtlBs:     seq[1] = char_t'("b");
      CtlFf:     seq[1] = char_t'("f");
      CtlLf:     seq[1] = char_t'("n");
      CtlCr:     seq[1] = char_t'("r");
      CtlHt:     seq[1] = char_t'("t");
      CtlVt:     seq[1] = char_t'("v");
      default: begin
        if (raw >= PrintLo && raw <= PrintHi) begin
          seq[0] = raw[6:0];
          n      = 1;
        end else begin
          seq[1] = char_t'("x");
          seq[2] = hex_char(raw[7:4]);
          seq[3] = hex_char(raw[3:0]);
          n      = 4;
        end
      end
    endcase
    for (int k = 0; k < n; k++) begin
      w.text_byte = seq[k];
      w.run_last  = (k == n - 1);
      w.text_end  = (k == n - 1) && str_end;
      text_due_q.push_back(w);
    end
  endfunction

  always @(posedge clk_i) begin : watch
    bec_word_t want;
    bec_word_t got;
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) begin
        got.text_byte = out_mon.text_byte;
        got.run_last  = out_mon.run_last;
        got.text_end  = out_mon.text_end;
        words_seen++;
        if (text_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportMax) begin
            $display("%0t: unexpected word char %h run_last %b text_end %b",
                     $realtime, got.text_byte, got.run_last, got.text_end);
          end
        end else begin
          want = text_due_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= ReportMax) begin
              $display("%0t: word %0d expected %h/%b/%b, got %h/%b/%b",
                       $realtime, words_seen, want.text_byte, want.run_last,
                       want.text_end, got.text_byte, got.run_last, got.text_end);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        queue_escape(in_mon.raw_byte, in_mon.string_end);
      end
      fail_count_o <= mismatches;
      pending_o    <= text_due_q.size();
      words_seen_o <= words_seen;
    end
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    StallNone,
    StallRandom,
    StallPeriodic,
    StallHeavy
  } stall_mode_e;

  typedef enum int {
    PickPrintable,
    PickBackslash,
    PickControl,
    PickLowOther,
    PickDelete,
    PickHigh,
    PickAny
  } byte_kind_e;

  localparam int RandomBytes = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int fail_count;
  int pending;
  int words_seen;
  int burst_left   = 0;
  int bytes_sent   = 0;
  int strings_done = 0;

  logic [7:0] directed_bytes[$] = '{8'h00, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C,
                                    8'h0D, 8'h06, 8'h0E, 8'h1F, 8'h20, 8'h41, 8'h5C,
                                    8'h7E, 8'h7F, 8'h80, 8'hA5, 8'hFF, 8'h5A, 8'hC3,
                                    8'h5C};

  bec_in_if  in_ch();
  bec_out_if out_ch();

  byte_escape_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  escape_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .words_seen_o (words_seen)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic send_byte(input logic [7:0] raw, input logic str_end);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(20, 60);
      end else begin
        burst_left = $urandom_range(1, 8);
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.raw_byte   <= raw;
    in_ch.string_end <= str_end;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
    if (str_end) begin
      strings_done++;
    end
  endtask

  // hold off until every expected word is out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    byte_kind_e kind;
    logic [7:0] b;
    kind = byte_kind_e'($urandom_range(0, 9) > 6 ? $urandom_range(0, 6) : 0);
    if ($urandom_range(0, 9) > 3) begin
      kind = byte_kind_e'($urandom_range(1, 6));
    end
    case (kind)
      PickPrintable: b = 8'($urandom_range(8'h20, 8'h7E));
      PickBackslash: b = 8'h5C;
      PickControl:   b = 8'($urandom_range(8'h07, 8'h0D));
      PickLowOther:  b = 8'($urandom_range(8'h00, 8'h1F));
      PickDelete:    b = 8'h7F;
      PickHigh:      b = 8'($urandom_range(8'h80, 8'hFF));
      default:       b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  initial begin : receiver
    stall_mode_e mode;
    int          span;
    int          cyc;
    out_ch.ready <= 1'b0;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(posedge clk_i);
        cyc++;
        case (mode)
          StallNone:     out_ch.ready <= 1'b1;
          StallRandom:   out_ch.ready <= 1'($urandom_range(0, 1));
          StallPeriodic: out_ch.ready <= (cyc % 5) != 0;
          default:       out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int   len;
    int   random_sent;
    logic noisy;
    logic paused;
    in_ch.valid      <= 1'b0;
    in_ch.raw_byte   <= 8'h00;
    in_ch.string_end <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_bytes[i]) begin
      send_byte(directed_bytes[i], (i % 4 == 3) || (i == directed_bytes.size() - 1));
    end
    wait_drained();

    random_sent = 0;
    paused      = 1'b0;
    while (random_sent < RandomBytes) begin
      len   = $urandom_range(1, 12);
      noisy = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        if (noisy) begin
          send_byte(pick_byte(), 1'($urandom_range(0, 1)));
        end else begin
          send_byte(pick_byte(), i == len - 1);
        end
        random_sent++;
      end
      if (!paused && random_sent >= RandomBytes / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("sent %0d bytes closing %0d strings, checked %0d escaped words",
             bytes_sent, strings_done, words_seen);
    $display("mixed printable, backslash, control, delete and high bytes under random stalls");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/bec_pkg.sv
design/bec_if.sv
design/bec_seq.sv
design/byte_escape_encoder.sv
dv/escape_checker.sv
dv/testbench.sv
